FILE: rtl/core/i2c_ram_pkg.sv
// Shared types and constants for the I2C register access master.
`timescale 1ns / 1ps
`default_nettype none

package i2c_ram_pkg;

    // Transaction phases of the bus engine.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_SEND_AW   = 4'd2,
        PH_ACK_AW    = 4'd3,
        PH_SEND_REG  = 4'd4,
        PH_ACK_REG   = 4'd5,
        PH_START_R   = 4'd6,
        PH_SEND_AR   = 4'd7,
        PH_ACK_AR    = 4'd8,
        PH_WAIT_BYTE = 4'd9,
        PH_SEND_DATA = 4'd10,
        PH_ACK_DATA  = 4'd11,
        PH_RECV      = 4'd12,
        PH_MACK      = 4'd13,
        PH_STOP      = 4'd14,
        PH_FSTOP     = 4'd15
    } phase_t;

    // Transaction modes.
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_PROBE = 2'd2,
        MODE_FIELD = 2'd3
    } mode_t;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam int         IN_DATA_W         = 40;
    localparam int         OUT_DATA_W        = 16;

    // Input request without the mode, lowest field in the lowest bits.
    typedef struct packed {
        logic [1:0] pad;
        logic       sda_in;
        logic [3:0] field_len;
        logic [2:0] field_msb;
        logic       wr_byte_valid;
        logic [7:0] wr_byte;
        logic [4:0] byte_count;
        logic [7:0] reg_addr;
        logic [6:0] dev_addr;
        logic       cmd_valid;
    } in_t;

    // One result per request, lowest field in the lowest bits.
    typedef struct packed {
        logic       status;
        logic       done_res;
        logic       busy_res;
        logic       byte_request;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       sda_oe;
        logic       sda_out;
        logic       scl;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/i2c_register_access_master.sv
// I2C register access master stepped once per bus delay tick.
//
//  channel | direction | payload
//  s_      | in        | s_tdata: tick request fields, s_tuser: mode
//  m_      | out       | m_tdata: bus drive, read byte and status
//  cfg_    | in        | cfg_data: ack_timeout
//
// One request is accepted per clock cycle while s_tready is high; each gives exactly one
// result (input register, then the combinational step of the phase machine into the
// result register). The phase machine advances only when a request moves into the
// result register. Reset leaves the engine idle and ack_timeout at 250.
// With m_tready low and a result pending, the result holds, the input register fills and s_tready drops.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master #(
    parameter int MAX_BYTES = 16
) (
    input  wire  logic                                 aclk,
    input  wire  logic                                 aresetn,
    // cmd_valid, dev_addr, reg_addr, byte_count, wr_byte, wr_byte_valid,
    // field_msb, field_len, sda_in, zero fill
    input  wire  logic [i2c_ram_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode
    input  wire  logic [1:0]                           s_tuser,
    input  wire  logic                                 s_tvalid,
    output logic                                       s_tready,
    // scl, sda_out, sda_oe, rd_byte, rd_valid, byte_request, busy_res,
    // done_res, status
    output logic [i2c_ram_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                       m_tvalid,
    input  wire  logic                                 m_tready,
    input  wire  logic [7:0]                           cfg_data,
    input  wire  logic                                 cfg_valid,
    output logic                                       cfg_ready
);
    import i2c_ram_pkg::*;

    localparam int         CNT_W    = $clog2(MAX_BYTES + 1);
    localparam logic [7:0] MAX_B8   = 8'(MAX_BYTES);

    // Handshake registers.
    in_t               in_reg;
    mode_t             in_mode_reg;
    logic              in_valid_reg;
    res_t              res_reg;
    logic              m_valid_reg;
    logic              advance;

    // Engine state.
    logic [7:0]        ack_timeout_reg;
    phase_t            phase_reg, phase_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [1:0]        tick_reg, tick_next;
    logic [7:0]        shift_reg, shift_next;
    logic [CNT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]        ack_wait_reg, ack_wait_next;
    logic [6:0]        held_dev_reg, held_dev_next;
    logic [7:0]        held_reg_reg, held_reg_next;
    mode_t             held_mode_reg, held_mode_next;
    logic [7:0]        field_value_reg, field_value_next;
    logic [7:0]        field_mask_reg, field_mask_next;
    logic              error_reg, error_next;

    // Step results.
    logic              scl, sda_drv, sda_oe, byte_request;
    logic [7:0]        rd_byte;
    logic              rd_valid, done, status;
    res_t              res_next;

    // Command decode helpers.
    logic [7:0]        cnt8, cnt_clip;
    logic [3:0]        msb_p1, len_clip, low;
    logic [15:0]       mask16, value16;
    logic [3:0]        bit_inc;
    logic              ack_seen, ack_ok;
    logic [CNT_W-1:0]  bytes_dec;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = res_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_reg      <= in_t'(s_tdata);
            in_mode_reg <= mode_t'(s_tuser);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ack_timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            tick_reg        <= '0;
            shift_reg       <= '0;
            bytes_left_reg  <= '0;
            ack_wait_reg    <= '0;
            held_dev_reg    <= '0;
            held_reg_reg    <= '0;
            held_mode_reg   <= MODE_WRITE;
            field_value_reg <= '0;
            field_mask_reg  <= '0;
            error_reg       <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            tick_reg        <= tick_next;
            shift_reg       <= shift_next;
            bytes_left_reg  <= bytes_left_next;
            ack_wait_reg    <= ack_wait_next;
            held_dev_reg    <= held_dev_next;
            held_reg_reg    <= held_reg_next;
            held_mode_reg   <= held_mode_next;
            field_value_reg <= field_value_next;
            field_mask_reg  <= field_mask_next;
            error_reg       <= error_next;
        end
    end

    // Command decode: byte count clip and field mask placement.
    always_comb begin
        cnt8 = {3'b000, in_reg.byte_count};
        if (cnt8 == 8'd0) begin
            cnt_clip = 8'd1;
        end else if (cnt8 > MAX_B8) begin
            cnt_clip = MAX_B8;
        end else begin
            cnt_clip = cnt8;
        end
        msb_p1   = {1'b0, in_reg.field_msb} + 4'd1;
        len_clip = (in_reg.field_len > msb_p1) ? msb_p1 : in_reg.field_len;
        low      = msb_p1 - len_clip;
        mask16   = ((16'd1 << len_clip) - 16'd1) << low;
        value16  = ({8'd0, in_reg.wr_byte} << low) & mask16;
    end

    // Bus drive for the current phase.
    always_comb begin
        scl          = 1'b0;
        sda_drv      = 1'b0;
        sda_oe       = 1'b1;
        byte_request = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                scl     = 1'b1;
                sda_drv = 1'b1;
            end
            PH_START_A, PH_START_R: begin
                scl     = (tick_reg != 2'd0);
                sda_drv = (tick_reg == 2'd0) || (tick_reg == 2'd1);
            end
            PH_STOP, PH_FSTOP: begin
                scl     = (tick_reg != 2'd0);
                sda_drv = !((tick_reg == 2'd0) || (tick_reg == 2'd1));
            end
            PH_SEND_AW, PH_SEND_REG, PH_SEND_AR, PH_SEND_DATA: begin
                scl     = (tick_reg != 2'd0);
                sda_drv = shift_reg[7];
            end
            PH_ACK_AW, PH_ACK_REG, PH_ACK_AR, PH_ACK_DATA, PH_RECV: begin
                scl    = (tick_reg != 2'd0);
                sda_oe = 1'b0;
            end
            PH_WAIT_BYTE: begin
                byte_request = 1'b1;
            end
            PH_MACK: begin
                scl     = (tick_reg != 2'd0);
                sda_drv = (bytes_left_reg <= CNT_W'(1));
            end
        endcase
    end

    // Next state of the engine for one tick.
    always_comb begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        tick_next        = tick_reg;
        shift_next       = shift_reg;
        bytes_left_next  = bytes_left_reg;
        ack_wait_next    = ack_wait_reg;
        held_dev_next    = held_dev_reg;
        held_reg_next    = held_reg_reg;
        held_mode_next   = held_mode_reg;
        field_value_next = field_value_reg;
        field_mask_next  = field_mask_reg;
        error_next       = error_reg;
        rd_byte          = 8'd0;
        rd_valid         = 1'b0;
        done             = 1'b0;
        status           = 1'b0;

        bit_inc   = {1'b0, bit_index_reg} + 4'd1;
        ack_ok    = !in_reg.sda_in;
        ack_seen  = ack_ok || (ack_wait_reg >= ack_timeout_reg);
        bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - CNT_W'(1) : bytes_left_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (in_reg.cmd_valid) begin
                    held_mode_next   = in_mode_reg;
                    held_dev_next    = in_reg.dev_addr;
                    held_reg_next    = in_reg.reg_addr;
                    field_mask_next  = mask16[7:0];
                    field_value_next = value16[7:0];
                    bytes_left_next  = (in_mode_reg == MODE_FIELD) ? CNT_W'(1)
                                                                   : CNT_W'(cnt_clip);
                    error_next       = 1'b0;
                    ack_wait_next    = '0;
                    bit_index_next   = '0;
                    tick_next        = '0;
                    phase_next       = PH_START_A;
                end
            end
            PH_START_A, PH_START_R: begin
                if (tick_reg == 2'd0) begin
                    tick_next = 2'd1;
                end else if (tick_reg == 2'd1) begin
                    tick_next = 2'd2;
                end else begin
                    tick_next      = '0;
                    bit_index_next = '0;
                    if (phase_reg == PH_START_A) begin
                        shift_next = {held_dev_reg, 1'b0};
                        phase_next = PH_SEND_AW;
                    end else begin
                        shift_next = {held_dev_reg, 1'b1};
                        phase_next = PH_SEND_AR;
                    end
                end
            end
            PH_STOP, PH_FSTOP: begin
                if (tick_reg == 2'd0) begin
                    tick_next = 2'd1;
                end else if (tick_reg == 2'd1) begin
                    tick_next = 2'd2;
                end else begin
                    tick_next = '0;
                    if (phase_reg == PH_FSTOP) begin
                        phase_next = PH_START_A;
                    end else begin
                        done       = 1'b1;
                        status     = error_reg;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_SEND_AW, PH_SEND_REG, PH_SEND_AR, PH_SEND_DATA: begin
                if (tick_reg == 2'd0) begin
                    tick_next = 2'd1;
                end else begin
                    tick_next  = '0;
                    shift_next = {shift_reg[6:0], 1'b0};
                    if (bit_inc[3]) begin
                        bit_index_next = '0;
                        ack_wait_next  = '0;
                        unique case (phase_reg)
                            PH_SEND_AW:  phase_next = PH_ACK_AW;
                            PH_SEND_REG: phase_next = PH_ACK_REG;
                            PH_SEND_AR:  phase_next = PH_ACK_AR;
                            default:     phase_next = PH_ACK_DATA;
                        endcase
                    end else begin
                        bit_index_next = bit_inc[2:0];
                    end
                end
            end
            PH_ACK_AW, PH_ACK_REG, PH_ACK_AR, PH_ACK_DATA: begin
                if (tick_reg == 2'd0) begin
                    tick_next = 2'd1;
                end else if (!ack_seen) begin
                    ack_wait_next = ack_wait_reg + 8'd1;
                end else begin
                    tick_next      = '0;
                    bit_index_next = '0;
                    unique case (phase_reg)
                        PH_ACK_AW: begin
                            if (!ack_ok) begin
                                error_next = 1'b1;
                                phase_next = PH_STOP;
                            end else if (held_mode_reg == MODE_PROBE) begin
                                phase_next = PH_STOP;
                            end else begin
                                shift_next = held_reg_reg;
                                phase_next = PH_SEND_REG;
                            end
                        end
                        // A NACK on the register address does not end the transfer.
                        PH_ACK_REG: begin
                            if (held_mode_reg == MODE_WRITE) begin
                                phase_next = PH_WAIT_BYTE;
                            end else if (held_mode_reg == MODE_FIELD
                                         && bytes_left_reg == '0) begin
                                shift_next = field_value_reg;
                                phase_next = PH_SEND_DATA;
                            end else if (held_mode_reg == MODE_PROBE) begin
                                phase_next = PH_STOP;
                            end else begin
                                phase_next = PH_START_R;
                            end
                        end
                        PH_ACK_AR: begin
                            shift_next = 8'd0;
                            phase_next = PH_RECV;
                        end
                        default: begin
                            if (!ack_ok) begin
                                error_next = 1'b1;
                                phase_next = PH_STOP;
                            end else if (held_mode_reg == MODE_FIELD) begin
                                phase_next = PH_STOP;
                            end else begin
                                bytes_left_next = bytes_dec;
                                phase_next = (bytes_dec == '0) ? PH_STOP : PH_WAIT_BYTE;
                            end
                        end
                    endcase
                end
            end
            PH_WAIT_BYTE: begin
                if (in_reg.wr_byte_valid) begin
                    shift_next     = in_reg.wr_byte;
                    bit_index_next = '0;
                    tick_next      = '0;
                    phase_next     = PH_SEND_DATA;
                end
            end
            PH_RECV: begin
                if (tick_reg == 2'd0) begin
                    tick_next = 2'd1;
                end else begin
                    tick_next  = '0;
                    shift_next = {shift_reg[6:0], in_reg.sda_in};
                    if (bit_inc[3]) begin
                        bit_index_next = '0;
                        rd_byte        = {shift_reg[6:0], in_reg.sda_in};
                        rd_valid       = 1'b1;
                        phase_next     = PH_MACK;
                    end else begin
                        bit_index_next = bit_inc[2:0];
                    end
                end
            end
            PH_MACK: begin
                if (tick_reg == 2'd0) begin
                    tick_next = 2'd1;
                end else begin
                    tick_next       = '0;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec != '0) begin
                        shift_next = 8'd0;
                        phase_next = PH_RECV;
                    end else if (held_mode_reg == MODE_FIELD) begin
                        // Merge the field into the byte just read, then write it back.
                        field_value_next = (shift_reg & ~field_mask_reg) | field_value_reg;
                        phase_next       = PH_FSTOP;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
            end
        endcase

        res_next.scl          = scl;
        res_next.sda_out      = sda_oe & sda_drv;
        res_next.sda_oe       = sda_oe;
        res_next.rd_byte      = rd_byte;
        res_next.rd_valid     = rd_valid;
        res_next.byte_request = byte_request;
        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.done_res     = done;
        res_next.status       = status;
    end

`ifndef SYNTHESIS
    // An error status only comes with the end of a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.status |-> res_reg.done_res && !res_reg.busy_res)
        else $error("status set without done");

    // While waiting for a write byte the engine holds SCL low and drives SDA.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.byte_request |-> !res_reg.scl && res_reg.sda_oe)
        else $error("byte request with bus not held");

    // The input side only stalls when both registers hold a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled without back pressure");

    // The remaining byte count never exceeds the configured maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= CNT_W'(MAX_BYTES))
        else $error("byte count out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/i2c_register_access_master_tb.sv
// Self-checking bench for the I2C register access master: scripted slave ticks, result compare.
`timescale 1ns / 1ps

module i2c_register_access_master_tb;
    import i2c_ram_pkg::*;

    localparam int MAX_BYTES = 16;

    typedef struct packed {
        mode_t mode;
        in_t   d;
    } tick_t;

    // Copy of the engine state kept by the bench.
    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_idx;
        logic [1:0] sub;
        logic [7:0] shreg;
        logic [4:0] left;
        logic [7:0] waited;
        logic [6:0] dev;
        logic [7:0] regad;
        mode_t      mode;
        logic [7:0] fval;
        logic [7:0] fmask;
        logic       err;
    } eng_t;

    // How the scripted slave answers the acknowledge slots of one transaction.
    typedef enum logic [1:0] {
        SLV_ACK,
        SLV_MUTE,
        SLV_ADDR_ONLY,
        SLV_NOISE
    } slave_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            cfg_data = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    tick_t      tick_q[$];
    res_t       bus_result_q[$];
    eng_t       plan = '0;
    eng_t       live = '0;
    eng_t       live_nxt;
    tick_t      offered = '0;
    res_t       pred_r;
    res_t       want_r;
    res_t       got;
    logic [7:0] ack_limit = ACK_TIMEOUT_RESET;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         err_cnt = 0;
    int         checked = 0;
    int         planned = 0;
    int         hold_ask = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    i2c_register_access_master #(.MAX_BYTES(MAX_BYTES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #10 aclk = ~aclk;

    // One bus tick of the engine: returns the bus drive and status, and the next state.
    function automatic res_t engine_step(input eng_t cur, input tick_t t,
                                         input logic [7:0] limit, output eng_t nxt);
        eng_t s;
        res_t r;
        logic so;
        logic oe;
        logic ok;
        logic acked;
        int   cnt;
        int   msb;
        int   len;
        int   low;
        s = cur;
        r = '0;
        so = 1'b0;
        oe = 1'b1;
        ok = 1'b0;
        acked = 1'b0;
        case (s.phase)
            PH_IDLE: begin
                r.scl = 1'b1;
                so = 1'b1;
                if (t.d.cmd_valid) begin
                    cnt = int'(t.d.byte_count);
                    if (cnt == 0) cnt = 1;
                    if (cnt > MAX_BYTES) cnt = MAX_BYTES;
                    msb = int'(t.d.field_msb);
                    len = int'(t.d.field_len);
                    if (len > msb + 1) len = msb + 1;
                    low = msb + 1 - len;
                    s.mode = t.mode;
                    s.dev = t.d.dev_addr;
                    s.regad = t.d.reg_addr;
                    s.fmask = 8'(((1 << len) - 1) << low);
                    s.fval = 8'(int'(t.d.wr_byte) << low) & s.fmask;
                    s.left = (t.mode == MODE_FIELD) ? 5'd1 : 5'(cnt);
                    s.err = 1'b0;
                    s.waited = '0;
                    s.bit_idx = '0;
                    s.sub = '0;
                    s.phase = PH_START_A;
                end
            end
            PH_START_A, PH_START_R: begin
                if (s.sub == 2'd0) begin
                    so = 1'b1;
                    s.sub = 2'd1;
                end else if (s.sub == 2'd1) begin
                    r.scl = 1'b1;
                    so = 1'b1;
                    s.sub = 2'd2;
                end else begin
                    r.scl = 1'b1;
                    s.sub = 2'd0;
                    s.bit_idx = '0;
                    if (s.phase == PH_START_A) begin
                        s.shreg = {s.dev, 1'b0};
                        s.phase = PH_SEND_AW;
                    end else begin
                        s.shreg = {s.dev, 1'b1};
                        s.phase = PH_SEND_AR;
                    end
                end
            end
            PH_STOP, PH_FSTOP: begin
                if (s.sub == 2'd0) begin
                    s.sub = 2'd1;
                end else if (s.sub == 2'd1) begin
                    r.scl = 1'b1;
                    s.sub = 2'd2;
                end else begin
                    r.scl = 1'b1;
                    so = 1'b1;
                    s.sub = 2'd0;
                    if (s.phase == PH_FSTOP) begin
                        s.phase = PH_START_A;
                    end else begin
                        r.done_res = 1'b1;
                        r.status = s.err;
                        s.phase = PH_IDLE;
                    end
                end
            end
            PH_SEND_AW, PH_SEND_REG, PH_SEND_AR, PH_SEND_DATA: begin
                so = s.shreg[7];
                if (s.sub == 2'd0) begin
                    s.sub = 2'd1;
                end else begin
                    r.scl = 1'b1;
                    s.sub = 2'd0;
                    s.shreg = {s.shreg[6:0], 1'b0};
                    s.bit_idx = s.bit_idx + 4'd1;
                    if (s.bit_idx >= 4'd8) begin
                        s.bit_idx = '0;
                        s.waited = '0;
                        s.phase = phase_t'(s.phase + 4'd1);
                    end
                end
            end
            PH_ACK_AW, PH_ACK_REG, PH_ACK_AR, PH_ACK_DATA: begin
                oe = 1'b0;
                if (s.sub == 2'd0) begin
                    s.sub = 2'd1;
                end else begin
                    r.scl = 1'b1;
                    if (!t.d.sda_in) begin
                        acked = 1'b1;
                        ok = 1'b1;
                    end else if (s.waited >= limit) begin
                        acked = 1'b1;
                    end else begin
                        s.waited = s.waited + 8'd1;
                    end
                end
                if (acked) begin
                    s.sub = '0;
                    s.bit_idx = '0;
                    case (s.phase)
                        PH_ACK_AW: begin
                            if (!ok) begin
                                s.err = 1'b1;
                                s.phase = PH_STOP;
                            end else if (s.mode == MODE_PROBE) begin
                                s.phase = PH_STOP;
                            end else begin
                                s.shreg = s.regad;
                                s.phase = PH_SEND_REG;
                            end
                        end
                        // A missing acknowledge on the register byte is not an error.
                        PH_ACK_REG: begin
                            if (s.mode == MODE_WRITE) begin
                                s.phase = PH_WAIT_BYTE;
                            end else if (s.mode == MODE_FIELD && s.left == 5'd0) begin
                                s.shreg = s.fval;
                                s.phase = PH_SEND_DATA;
                            end else if (s.mode == MODE_PROBE) begin
                                s.phase = PH_STOP;
                            end else begin
                                s.phase = PH_START_R;
                            end
                        end
                        PH_ACK_AR: begin
                            s.shreg = '0;
                            s.phase = PH_RECV;
                        end
                        default: begin
                            if (!ok) begin
                                s.err = 1'b1;
                                s.phase = PH_STOP;
                            end else if (s.mode == MODE_FIELD) begin
                                s.phase = PH_STOP;
                            end else begin
                                if (s.left != 5'd0) s.left = s.left - 5'd1;
                                s.phase = (s.left == 5'd0) ? PH_STOP : PH_WAIT_BYTE;
                            end
                        end
                    endcase
                end
            end
            PH_WAIT_BYTE: begin
                r.byte_request = 1'b1;
                if (t.d.wr_byte_valid) begin
                    s.shreg = t.d.wr_byte;
                    s.bit_idx = '0;
                    s.sub = '0;
                    s.phase = PH_SEND_DATA;
                end
            end
            PH_RECV: begin
                oe = 1'b0;
                if (s.sub == 2'd0) begin
                    s.sub = 2'd1;
                end else begin
                    r.scl = 1'b1;
                    s.sub = 2'd0;
                    s.shreg = {s.shreg[6:0], t.d.sda_in};
                    s.bit_idx = s.bit_idx + 4'd1;
                    if (s.bit_idx >= 4'd8) begin
                        s.bit_idx = '0;
                        r.rd_byte = s.shreg;
                        r.rd_valid = 1'b1;
                        s.phase = PH_MACK;
                    end
                end
            end
            PH_MACK: begin
                // The master NACKs the last byte it reads.
                so = (s.left <= 5'd1);
                if (s.sub == 2'd0) begin
                    s.sub = 2'd1;
                end else begin
                    r.scl = 1'b1;
                    s.sub = 2'd0;
                    if (s.left != 5'd0) s.left = s.left - 5'd1;
                    if (s.left != 5'd0) begin
                        s.shreg = '0;
                        s.phase = PH_RECV;
                    end else if (s.mode == MODE_FIELD) begin
                        s.fval = (s.shreg & ~s.fmask) | s.fval;
                        s.phase = PH_FSTOP;
                    end else begin
                        s.phase = PH_STOP;
                    end
                end
            end
            default: begin
                r.scl = 1'b1;
                so = 1'b1;
                s.phase = PH_IDLE;
                s.sub = '0;
                s.bit_idx = '0;
            end
        endcase
        r.sda_oe = oe;
        r.sda_out = oe & so;
        r.busy_res = (s.phase != PH_IDLE);
        nxt = s;
        return r;
    endfunction

    function automatic tick_t rand_tick();
        tick_t       t;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        t.mode = mode_t'($urandom_range(0, 3));
        t.d = bits[IN_DATA_W-1:0];
        t.d.pad = '0;
        return t;
    endfunction

    // Queues a tick and advances the planning copy so later ticks can answer the engine.
    task automatic push_tick(input tick_t t);
        eng_t nxt;
        void'(engine_step(plan, t, ack_limit, nxt));
        plan = nxt;
        tick_q.push_back(t);
        planned++;
    endtask

    task automatic run_txn(input mode_t m, input logic [6:0] dev, input logic [7:0] ra,
                           input logic [4:0] cnt, input logic [7:0] wb, input logic [2:0] msb,
                           input logic [3:0] len, input slave_t kind);
        tick_t t;
        t = rand_tick();
        t.mode = m;
        t.d.cmd_valid = 1'b1;
        t.d.dev_addr = dev;
        t.d.reg_addr = ra;
        t.d.byte_count = cnt;
        t.d.wr_byte = wb;
        t.d.field_msb = msb;
        t.d.field_len = len;
        push_tick(t);
        // Ticks inside the transaction carry random noise, commands included.
        while (plan.phase != PH_IDLE) begin
            t = rand_tick();
            case (plan.phase)
                PH_ACK_AW, PH_ACK_REG, PH_ACK_AR, PH_ACK_DATA: begin
                    if (plan.sub != 2'd0) begin
                        case (kind)
                            SLV_ACK:       t.d.sda_in = ($urandom_range(0, 3) == 0);
                            SLV_MUTE:      t.d.sda_in = 1'b1;
                            SLV_ADDR_ONLY: t.d.sda_in = (plan.phase != PH_ACK_AW);
                            default:       ;
                        endcase
                    end
                end
                PH_WAIT_BYTE: t.d.wr_byte_valid = ($urandom_range(0, 2) != 0);
                default: ;
            endcase
            push_tick(t);
        end
    endtask

    task automatic random_txn();
        int     r;
        logic [4:0] cnt;
        slave_t kind;
        tick_t  t;
        r = $urandom_range(0, 9);
        if (r < 7) cnt = 5'($urandom_range(1, 4));
        else if (r < 8) cnt = 5'($urandom_range(5, 16));
        else if (r < 9) cnt = 5'd0;
        else cnt = 5'($urandom_range(17, 31));
        r = $urandom_range(0, 9);
        if (r < 7) kind = SLV_ACK;
        else if (r == 7) kind = SLV_MUTE;
        else if (r == 8) kind = SLV_ADDR_ONLY;
        else kind = SLV_NOISE;
        run_txn(mode_t'($urandom_range(0, 3)), 7'($urandom), 8'($urandom), cnt,
                8'($urandom), 3'($urandom), 4'($urandom), kind);
        repeat ($urandom_range(0, 3)) begin
            t = rand_tick();
            t.d.cmd_valid = 1'b0;
            push_tick(t);
        end
    endtask

    task automatic write_timeout(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ack_limit = v;
    endtask

    // The sender stays quiet until every expected result is back.
    task automatic drain();
        while (tick_q.size() != 0 || s_tvalid || bus_result_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pred_r = engine_step(live, offered, ack_limit, live_nxt);
                live = live_nxt;
                bus_result_q.push_back(pred_r);
            end
            if (!s_tvalid || s_tready) begin
                if (tick_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    offered = tick_q.pop_front();
                    s_tdata <= offered.d;
                    s_tuser <= offered.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (bus_result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("result %0d arrived with none expected: %h",
                                                checked, got);
                end else begin
                    want_r = bus_result_q.pop_front();
                    if (got !== want_r) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"result %0d scl/sda/oe/rd/rv/req/busy/done/st ",
                                      "want %b %b %b %h %b %b %b %b %b ",
                                      "got %b %b %b %h %b %b %b %b %b"}, checked,
                                     want_r.scl, want_r.sda_out, want_r.sda_oe,
                                     want_r.rd_byte, want_r.rd_valid, want_r.byte_request,
                                     want_r.busy_res, want_r.done_res, want_r.status,
                                     got.scl, got.sda_out, got.sda_oe, got.rd_byte,
                                     got.rd_valid, got.byte_request, got.busy_res,
                                     got.done_res, got.status);
                    end
                end
                checked++;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        int gaps[5];
        int stalls[5];
        int limits[5];
        gaps = '{0, 54, 0, 13, 0};
        stalls = '{0, 0, 54, 13, 0};
        limits = '{1, 255, 4, 250, 7};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed transactions under the reset timeout.
        run_txn(MODE_WRITE, 7'h7f, 8'hff, 5'd1, 8'hff, 3'd7, 4'd8, SLV_ACK);
        run_txn(MODE_WRITE, 7'h00, 8'h00, 5'd0, 8'h00, 3'd0, 4'd0, SLV_ACK);
        run_txn(MODE_READ, 7'h55, 8'h80, 5'd2, 8'h00, 3'd0, 4'd1, SLV_ACK);
        run_txn(MODE_READ, 7'h2a, 8'h7f, 5'd31, 8'h00, 3'd0, 4'd1, SLV_NOISE);
        run_txn(MODE_PROBE, 7'h48, 8'h10, 5'd3, 8'h00, 3'd0, 4'd1, SLV_ACK);
        run_txn(MODE_PROBE, 7'h11, 8'h22, 5'd1, 8'h00, 3'd0, 4'd1, SLV_MUTE);
        run_txn(MODE_FIELD, 7'h3c, 8'h05, 5'd1, 8'ha5, 3'd7, 4'd8, SLV_ACK);
        run_txn(MODE_FIELD, 7'h3c, 8'h06, 5'd1, 8'hff, 3'd3, 4'd0, SLV_ACK);
        run_txn(MODE_FIELD, 7'h3c, 8'h07, 5'd1, 8'h5a, 3'd2, 4'd15, SLV_ACK);
        run_txn(MODE_FIELD, 7'h01, 8'h08, 5'd16, 8'h01, 3'd0, 4'd1, SLV_ACK);
        drain();

        // A short timeout keeps the slave that only answers its address brief.
        write_timeout(8'd3);
        run_txn(MODE_WRITE, 7'h20, 8'h30, 5'd3, 8'h00, 3'd0, 4'd1, SLV_ADDR_ONLY);
        run_txn(MODE_READ, 7'h21, 8'h31, 5'd2, 8'h00, 3'd0, 4'd1, SLV_ADDR_ONLY);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            gap_pct = gaps[ph];
            stall_pct = stalls[ph];
            write_timeout(8'(limits[ph]));
            planned = 0;
            while (planned < 80) random_txn();
            if (ph == 4) begin
                // Long receiver hold-off while the sender keeps offering ticks.
                @(posedge aclk);
                hold_ask <= hold_ask + 1;
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (err_cnt == 0 && bus_result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
